/* rtl/mbe_pkg.sv */
// Shared types, codes and helper functions for the maze backtrack explorer.
`timescale 1ns / 1ps

package mbe_pkg;

  // Field widths fixed by the interface
  localparam int DIST_W = 14;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT  = 2'd1;

  // Register reset values
  localparam logic [DIST_W-1:0] NEAR_RESET = 14'd160;
  localparam logic [DIST_W-1:0] FAR_RESET  = 14'd3200;

  // Results kept per step, and the width of their counter
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd36;

  // Move codes on the result channel
  typedef enum logic [2:0] {
    MV_NONE  = 3'd0,
    MV_FWD   = 3'd1,
    MV_LEFT  = 3'd2,
    MV_RIGHT = 3'd3,
    MV_ABOUT = 3'd4
  } mv_t;

  // Codes stored in the move history
  typedef enum logic [1:0] {
    H_NONE = 2'd0,
    H_F    = 2'd1,
    H_L    = 2'd2,
    H_R    = 2'd3
  } hcode_t;

  // Range reading classes
  typedef enum logic [1:0] {
    CLS_BLOCKED = 2'd0,
    CLS_OPEN    = 2'd1,
    CLS_FAR     = 2'd2
  } cls_t;

  // One result beat
  typedef struct packed {
    mv_t  mv;
    logic finished;
    logic full;
  } res_t;

  // Sequencer to result stage
  typedef struct packed {
    logic push;
    logic flush;
    res_t res;
  } emit_req_t;

  // Result stage back to sequencer
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
    logic pending;
  } emit_rsp_t;

  // Sequencer status for checking
  typedef struct packed {
    logic done;
    logic hist_over;
  } seq_status_t;

  // Far test first, so far wins when the limits overlap
  function automatic cls_t classify(input logic [DIST_W-1:0] d,
                                    input logic [DIST_W-1:0] near,
                                    input logic [DIST_W-1:0] far);
    cls_t c;
    if (d > far) begin
      c = CLS_FAR;
    end else if (d <= near) begin
      c = CLS_BLOCKED;
    end else begin
      c = CLS_OPEN;
    end
    return c;
  endfunction

  // Move that a recorded history code stands for
  function automatic mv_t rec_move(input hcode_t h);
    mv_t m;
    case (h)
      H_F:     m = MV_FWD;
      H_L:     m = MV_LEFT;
      H_R:     m = MV_RIGHT;
      default: m = MV_NONE;
    endcase
    return m;
  endfunction

  // Mirrored move used while replaying back to a junction
  function automatic mv_t mirror_move(input hcode_t h);
    mv_t m;
    case (h)
      H_F:     m = MV_FWD;
      H_L:     m = MV_RIGHT;
      H_R:     m = MV_LEFT;
      default: m = MV_NONE;
    endcase
    return m;
  endfunction

  // Reorientation at the junction toward the next branch
  function automatic mv_t reorient_move(input hcode_t h);
    mv_t m;
    case (h)
      H_F:     m = MV_ABOUT;
      H_L:     m = MV_LEFT;
      H_R:     m = MV_RIGHT;
      default: m = MV_NONE;
    endcase
    return m;
  endfunction

endpackage

/* rtl/mbe_ram.sv */
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps

module mbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mbe_result_stage.sv */
// Result stage: one pending beat plus the output register, marks the final beat.
`timescale 1ns / 1ps

module mbe_result_stage (
  input  logic               clk,
  input  logic               rst,
  input  mbe_pkg::emit_req_t req,
  output mbe_pkg::emit_rsp_t rsp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         move,
  output logic               finished,
  output logic               history_full,
  output logic               last
);

  import mbe_pkg::*;

  logic held_v;
  res_t held;
  logic out_load;

  // a beat is held back until it is known whether it ends the run
  assign rsp.push_ok  = !held_v || !out_valid || out_ready;
  assign rsp.flush_ok = !out_valid || out_ready;
  assign rsp.pending  = held_v;

  assign out_load = (req.push || req.flush) && held_v;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      held_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.push) begin
        held_v <= 1'b1;
      end else if (req.flush) begin
        held_v <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.push) begin
      held <= req.res;
    end
    if (out_load) begin
      move         <= held.mv;
      finished     <= held.finished;
      history_full <= held.full;
      last         <= req.flush;
    end
  end

endmodule

/* rtl/mbe_seq.sv */
// Step sequencer: classifies readings, walks the history and junction memories.
`timescale 1ns / 1ps

module mbe_seq #(
  parameter int HISTORY_DEPTH  = 32,
  parameter int JUNCTION_DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [mbe_pkg::DIST_W-1:0]            front_distance,
  input  logic [mbe_pkg::DIST_W-1:0]            left_distance,
  input  logic [mbe_pkg::DIST_W-1:0]            right_distance,
  input  logic [mbe_pkg::DIST_W-1:0]            near_limit,
  input  logic [mbe_pkg::DIST_W-1:0]            far_limit,
  // junction memory: position and tried count
  output logic                                  j_we,
  output logic [$clog2(JUNCTION_DEPTH)-1:0]     j_waddr,
  output logic [$clog2(HISTORY_DEPTH+1)+1:0]    j_wdata,
  output logic [$clog2(JUNCTION_DEPTH)-1:0]     j_raddr,
  input  logic [$clog2(HISTORY_DEPTH+1)+1:0]    j_rdata,
  // history memory
  output logic                                  h_we,
  output logic [$clog2(HISTORY_DEPTH)-1:0]      h_waddr,
  output logic [1:0]                            h_wdata,
  output logic                                  h_re,
  output logic [$clog2(HISTORY_DEPTH)-1:0]      h_raddr,
  input  logic [1:0]                            h_rdata,
  // result stage
  output mbe_pkg::emit_req_t                    req,
  input  mbe_pkg::emit_rsp_t                    rsp,
  output mbe_pkg::seq_status_t                  status
);

  import mbe_pkg::*;

  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int JW  = $clog2(JUNCTION_DEPTH);
  localparam logic [HCW-1:0] HD_C = HCW'(HISTORY_DEPTH);
  localparam logic [JW-1:0]  JTOP = JW'(JUNCTION_DEPTH - 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECIDE = 11'b000_0000_0010,
    S_REC    = 11'b000_0000_0100,
    S_ONE    = 11'b000_0000_1000,
    S_POP    = 11'b000_0001_0000,
    S_JWAIT  = 11'b000_0010_0000,
    S_BT0    = 11'b000_0100_0000,
    S_BTEM   = 11'b000_1000_0000,
    S_BTJF   = 11'b001_0000_0000,
    S_BTOR   = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic [HCW-1:0] hcount, hcount_next;
  logic [JW-1:0]  stop, stop_next;
  logic           done, done_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [HISTORY_DEPTH-1:0]  hvalid;
  logic [JUNCTION_DEPTH-1:0] jvalid;

  // payload registers
  cls_t cf, cl, cr;
  hcode_t rec_code, rec_code_next;
  logic   rec_two, rec_two_next;
  mv_t    one_mv, one_mv_next;
  logic [HCW-1:0] pos, pos_next;
  logic jv_q, hv_q;

  // memory read views
  logic [HCW-1:0] jpos;
  logic [1:0]     tried;
  logic           at_j;
  hcode_t         h_code;
  logic [HCW-1:0] h_addr;
  logic           h_in;

  // emit control
  logic want_emit, keep, go;
  res_t emit_res;
  logic [HCW-1:0] pi, pn;
  logic push_en, pop_en;
  logic accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign j_raddr  = stop;

  assign jpos   = jv_q ? j_rdata[HCW+1:2] : '0;
  assign tried  = jv_q ? j_rdata[1:0] : 2'd0;
  assign at_j   = (hcount == jpos);
  assign h_code = hv_q ? hcode_t'(h_rdata) : H_NONE;

  assign h_in    = (h_addr < HD_C);
  assign h_raddr = h_in ? h_addr[HAW-1:0] : '0;

  assign pi = (hcount != '0) ? hcount - HCW'(1) : '0;
  assign pn = pos - HCW'(1);

  assign status.done      = done;
  assign status.hist_over = (hcount > HD_C);

  // what the current state wants to send
  always_comb begin
    want_emit = 1'b0;
    emit_res  = '{mv: MV_NONE, finished: done, full: 1'b0};
    case (state)
      S_REC: begin
        want_emit     = 1'b1;
        emit_res.mv   = rec_move(rec_code);
        emit_res.full = (hcount >= HD_C);
      end
      S_ONE: begin
        want_emit   = 1'b1;
        emit_res.mv = one_mv;
      end
      S_BT0: begin
        want_emit   = 1'b1;
        emit_res.mv = MV_ABOUT;
      end
      S_BTEM: begin
        want_emit   = (h_code != H_NONE);
        emit_res.mv = mirror_move(h_code);
      end
      S_BTJF: begin
        want_emit   = (h_code == H_F);
        emit_res.mv = MV_FWD;
      end
      S_BTOR: begin
        want_emit   = (h_code != H_NONE);
        emit_res.mv = reorient_move(h_code);
      end
      default: begin
        want_emit = 1'b0;
      end
    endcase
  end

  // beats past the per-step cap are dropped, the walk goes on
  assign keep = (cnt < MAX_RESULTS);
  assign go   = !want_emit || !keep || rsp.push_ok;

  // next state and memory control
  always_comb begin
    state_next    = state;
    hcount_next   = hcount;
    stop_next     = stop;
    done_next     = done;
    cnt_next      = cnt;
    rec_code_next = rec_code;
    rec_two_next  = rec_two;
    one_mv_next   = one_mv;
    pos_next      = pos;
    j_we    = 1'b0;
    j_waddr = stop;
    j_wdata = {jpos, 2'd0};
    h_we    = 1'b0;
    h_waddr = hcount[HAW-1:0];
    h_wdata = rec_code;
    h_re    = 1'b0;
    h_addr  = pos;
    push_en = 1'b0;
    pop_en  = 1'b0;
    req.push  = want_emit && keep && rsp.push_ok;
    req.flush = 1'b0;
    req.res   = emit_res;

    if (req.push) begin
      cnt_next = cnt + CNT_W'(1);
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          if (done) begin
            one_mv_next = MV_NONE;
            state_next  = S_ONE;
          end else begin
            state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        rec_two_next = 1'b1;
        if (cf == CLS_OPEN && (!at_j || tried == 2'd0)) begin
          push_en       = (cl == CLS_OPEN) || (cr == CLS_OPEN);
          rec_code_next = H_F;
          rec_two_next  = 1'b0;
          state_next    = S_REC;
        end else if (cl == CLS_OPEN && (!at_j || tried < 2'd2)) begin
          push_en       = (cr == CLS_OPEN);
          rec_code_next = H_L;
          state_next    = S_REC;
        end else if (cr == CLS_OPEN && (!at_j || tried != 2'd3)) begin
          rec_code_next = H_R;
          state_next    = S_REC;
        end else if (cf == CLS_FAR) begin
          if (cl == CLS_FAR && cr == CLS_FAR) begin
            done_next   = 1'b1;
            one_mv_next = MV_NONE;
          end else begin
            one_mv_next = MV_FWD;
          end
          state_next = S_ONE;
        end else begin
          state_next = S_POP;
        end
        // push the new junction, ignored when the stack is full
        if (push_en && stop != JTOP) begin
          j_we      = 1'b1;
          j_waddr   = stop + JW'(1);
          j_wdata   = {hcount, 2'd0};
          stop_next = stop + JW'(1);
        end
      end
      S_REC: begin
        if (go) begin
          if (hcount < HD_C) begin
            h_we        = 1'b1;
            hcount_next = hcount + HCW'(1);
          end
          if (rec_two) begin
            rec_code_next = H_F;
            rec_two_next  = 1'b0;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_ONE: begin
        if (go) begin
          state_next = S_FIN;
        end
      end
      S_POP: begin
        // junction exhausted: clear its count and drop it
        pop_en = ((tried == 2'd2) && (cr == CLS_BLOCKED)) || (tried == 2'd3);
        if (pop_en) begin
          j_we    = 1'b1;
          j_wdata = {jpos, 2'd0};
          if (stop != '0) begin
            stop_next = stop - JW'(1);
          end
        end
        state_next = S_JWAIT;
      end
      S_JWAIT: begin
        state_next = S_BT0;
      end
      S_BT0: begin
        if (go) begin
          pos_next = pi;
          h_re     = 1'b1;
          if (pi > jpos) begin
            h_addr     = pi;
            state_next = S_BTEM;
          end else begin
            h_addr     = jpos;
            state_next = S_BTJF;
          end
        end
      end
      S_BTEM: begin
        // replay one entry per cycle unless the result stage stalls, next read issued as this one is used
        if (go) begin
          pos_next = pn;
          h_re     = 1'b1;
          if (pn > jpos) begin
            h_addr = pn;
          end else begin
            h_addr     = jpos;
            state_next = S_BTJF;
          end
        end
      end
      S_BTJF: begin
        if (go) begin
          hcount_next = pos;
          h_re        = 1'b1;
          h_addr      = pos;
          state_next  = S_BTOR;
        end
      end
      S_BTOR: begin
        if (go) begin
          if (h_code != H_NONE) begin
            j_we    = 1'b1;
            j_wdata = {jpos, h_code};
          end
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (rsp.flush_ok) begin
          req.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      hcount <= '0;
      stop   <= '0;
      done   <= 1'b0;
      cnt    <= '0;
      hvalid <= '0;
      jvalid <= '0;
    end else begin
      state  <= state_next;
      hcount <= hcount_next;
      stop   <= stop_next;
      done   <= done_next;
      cnt    <= cnt_next;
      if (h_we) begin
        hvalid[h_waddr] <= 1'b1;
      end
      if (j_we) begin
        jvalid[j_waddr] <= 1'b1;
      end
    end
  end

  // payload registers and valid flags that follow the memory reads
  always_ff @(posedge clk) begin
    if (accept) begin
      cf <= classify(front_distance, near_limit, far_limit);
      cl <= classify(left_distance, near_limit, far_limit);
      cr <= classify(right_distance, near_limit, far_limit);
    end
    rec_code <= rec_code_next;
    rec_two  <= rec_two_next;
    one_mv   <= one_mv_next;
    pos      <= pos_next;
    jv_q     <= jvalid[stop];
    if (h_re) begin
      hv_q <= h_in && hvalid[h_raddr];
    end
  end

endmodule

/* rtl/maze_backtrack_explorer_unit.sv */
// Top level of the maze backtrack explorer: config registers, memories, sequencer.
`timescale 1ns / 1ps

// Depth-first maze walker. Each input beat carries front, left and right
// ranges; the unit answers with a run of move beats, the final one flagged
// by last. Items are handled one at a time. A dead end replays the history
// back to the junction, reading the history memory one entry per cycle
// unless the result channel stalls. Memories need no clearing pass:
// entries never written read as zero through per-entry valid flops.
// Config registers: index 0 near_limit, index 1 far_limit, to be written
// while idle; the unit itself does not enforce this.

module maze_backtrack_explorer_unit #(
  parameter int HISTORY_DEPTH  = 32,
  parameter int JUNCTION_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // item channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mbe_pkg::DIST_W-1:0]           front_distance,
  input  logic [mbe_pkg::DIST_W-1:0]           left_distance,
  input  logic [mbe_pkg::DIST_W-1:0]           right_distance,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           move,
  output logic                                 finished,
  output logic                                 history_full,
  output logic                                 last,
  // config channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mbe_pkg::DIST_W-1:0]           cfg_data
);

  import mbe_pkg::*;

  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int JW  = $clog2(JUNCTION_DEPTH);

  logic [DIST_W-1:0] near_limit, far_limit;

  logic          j_we;
  logic [JW-1:0] j_waddr, j_raddr;
  logic [HCW+1:0] j_wdata, j_rdata;
  logic           h_we, h_re;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [1:0]     h_wdata, h_rdata;

  emit_req_t   req;
  emit_rsp_t   rsp;
  seq_status_t status;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= NEAR_RESET;
      far_limit  <= FAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEAR_LIMIT: near_limit <= cfg_data;
        CFG_FAR_LIMIT:  far_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // junction stack memory: {position, tried}
  mbe_ram #(
    .WIDTH (HCW + 2),
    .DEPTH (JUNCTION_DEPTH)
  ) u_junction_ram (
    .clk   (clk),
    .we    (j_we),
    .waddr (j_waddr),
    .wdata (j_wdata),
    .re    (1'b1),
    .raddr (j_raddr),
    .rdata (j_rdata)
  );

  // move history memory
  mbe_ram #(
    .WIDTH (2),
    .DEPTH (HISTORY_DEPTH)
  ) u_history_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  mbe_seq #(
    .HISTORY_DEPTH  (HISTORY_DEPTH),
    .JUNCTION_DEPTH (JUNCTION_DEPTH)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .front_distance (front_distance),
    .left_distance  (left_distance),
    .right_distance (right_distance),
    .near_limit     (near_limit),
    .far_limit      (far_limit),
    .j_we           (j_we),
    .j_waddr        (j_waddr),
    .j_wdata        (j_wdata),
    .j_raddr        (j_raddr),
    .j_rdata        (j_rdata),
    .h_we           (h_we),
    .h_waddr        (h_waddr),
    .h_wdata        (h_wdata),
    .h_re           (h_re),
    .h_raddr        (h_raddr),
    .h_rdata        (h_rdata),
    .req            (req),
    .rsp            (rsp),
    .status         (status)
  );

  mbe_result_stage u_result (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .move         (move),
    .finished     (finished),
    .history_full (history_full),
    .last         (last)
  );

`ifndef NO_ASSERTIONS
  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one in work");

  // a new item never starts with a beat of the previous run still held back
  a_no_stale_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !rsp.pending)
    else $error("pending beat left over at item accept");

  // end of maze is sticky
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    status.done |=> status.done)
    else $error("finished flag dropped");

  // history count saturates at the depth
  a_hist_bound: assert property (@(posedge clk) disable iff (rst)
    !status.hist_over)
    else $error("history count beyond depth");
`endif

endmodule
